/* rtl/ftcl_pkg.sv */
// Package: shared types and constants of the fog coefficient lookup.
`timescale 1ns / 1ps
`default_nettype none
package ftcl_pkg;

    localparam int TABLE_ENTRIES = 128;
    localparam int IDX_W         = 7;
    localparam int ENTRY_W       = 16;
    localparam int LEVEL_W       = 27;
    localparam int FRAC_W        = 19;
    localparam int MANT_W        = 23;

    localparam logic [23:0]       SIG_HIGH      = 24'hFFFFF9;
    localparam logic [MANT_W-1:0] Z_HIGH_MANT   = 23'h7FFFF9;
    localparam logic signed [10:0] K_NORM_OFFSET = 11'sd157;
    localparam logic signed [10:0] K_SUB_OFFSET  = 11'sd156;

    typedef enum logic [1:0] {
        CLAMP_NONE = 2'd0,
        CLAMP_LOW  = 2'd1,
        CLAMP_HIGH = 2'd2
    } clamp_t;

    typedef struct packed {
        logic                 cmd;
        logic [IDX_W-1:0]     entry_index;
        logic [ENTRY_W-1:0]   entry_data;
        logic                 bad;
        clamp_t               clamp;
        logic [31:0]          prod;
        logic signed [10:0]   k;
    } s1_t;

    typedef struct packed {
        logic                 cmd;
        logic [IDX_W-1:0]     entry_index;
        logic [ENTRY_W-1:0]   entry_data;
        logic                 bad;
        clamp_t               clamp;
        logic [31:0]          prod;
        logic [4:0]           lzc;
        logic [2:0]           ez;
    } s2_t;

    typedef struct packed {
        logic                 cmd;
        logic [IDX_W-1:0]     entry_index;
        logic [ENTRY_W-1:0]   entry_data;
        logic                 bad;
        logic [IDX_W-1:0]     table_idx;
        logic [FRAC_W-1:0]    frac;
    } s3_t;

    typedef struct packed {
        logic                 bad;
        logic [FRAC_W-1:0]    frac;
    } s4_t;

    typedef struct packed {
        logic                 bad;
        logic [7:0]           cur;
        logic signed [28:0]   iprod;
    } s5_t;

endpackage
`default_nettype wire

/* rtl/ftcl_ram.sv */
// Generic simple dual-port RAM with registered read.
`timescale 1ns / 1ps
`default_nettype none
module ftcl_ram #(
    parameter int WIDTH = 16,
    parameter int DEPTH = 128
) (
    input  wire logic                     clk,
    input  wire logic                     wr_en,
    input  wire logic [$clog2(DEPTH)-1:0] wr_addr,
    input  wire logic [WIDTH-1:0]         wr_data,
    input  wire logic                     rd_en,
    input  wire logic [$clog2(DEPTH)-1:0] rd_addr,
    output logic      [WIDTH-1:0]         rd_data
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk) begin
        if (wr_en) begin
            mem[wr_addr] <= wr_data;
        end
        if (rd_en) begin
            rd_data <= mem[rd_addr];
        end
    end

endmodule
`default_nettype wire

/* rtl/fog_table_coefficient_lookup.sv */
// Throughput: one beat per cycle while m_tready does not stall the output; table write beats produce no result.
// Stages: multiply, leading-zero count, normalise/round/clamp, table read,
//   interpolation multiply, final add into the output register.
// Reset: synchronous, clears valid bits and the density register; table
//   contents are undefined until written.
`timescale 1ns / 1ps
`default_nettype none
module fog_table_coefficient_lookup (
    input  wire logic        aclk,
    input  wire logic        aresetn,
    input  wire logic        cfg_wen,
    input  wire logic [15:0] cfg_wdata,
    input  wire logic        s_tvalid,
    output logic             s_tready,
    input  wire logic [55:0] s_tdata,   // entry_index, entry_data, reciprocal_depth_bits, pad
    input  wire logic        s_tuser,   // command
    output logic             m_tvalid,
    input  wire logic        m_tready,
    output logic      [31:0] m_tdata,   // fog_level, pad
    output logic             m_tuser    // bad_depth
);

    logic [15:0] packed_density_reg;

    logic v1_reg, v2_reg, v3_reg, v4_reg, v5_reg, m_tvalid_reg;
    logic rdy1, rdy2, rdy3, rdy4, rdy5, rdy6;

    ftcl_pkg::s1_t s1_reg, s1_next;
    ftcl_pkg::s2_t s2_reg, s2_next;
    ftcl_pkg::s3_t s3_reg, s3_next;
    ftcl_pkg::s4_t s4_reg, s4_next;
    ftcl_pkg::s5_t s5_reg, s5_next;
    logic [ftcl_pkg::LEVEL_W-1:0] level_reg, level_next;
    logic                         bad_reg;

    logic                          ram_wr_en, ram_rd_en;
    logic [ftcl_pkg::ENTRY_W-1:0]  ram_rd_data;

    assign rdy6     = !m_tvalid_reg || m_tready;
    assign rdy5     = !v5_reg || rdy6;
    assign rdy4     = !v4_reg || rdy5;
    assign rdy3     = !v3_reg || rdy4;
    assign rdy2     = !v2_reg || rdy3;
    assign rdy1     = !v1_reg || rdy2;
    assign s_tready = rdy1;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            packed_density_reg <= '0;
        end else if (cfg_wen) begin
            packed_density_reg <= cfg_wdata;
        end
    end

    // Stage 1: decode and mantissa product
    always_comb begin
        logic [31:0] rbits;
        logic [7:0]  er;
        logic [22:0] mant;
        logic [7:0]  dm;
        logic [7:0]  de;
        logic [23:0] sig24;
        rbits = s_tdata[54:23];
        er    = rbits[30:23];
        mant  = rbits[22:0];
        dm    = packed_density_reg[15:8];
        de    = packed_density_reg[7:0];
        sig24 = {er != 8'd0, mant};
        s1_next.cmd         = s_tuser;
        s1_next.entry_index = s_tdata[6:0];
        s1_next.entry_data  = s_tdata[22:7];
        s1_next.bad         = ((er == 8'hFF) && (mant != 23'd0))
                            || (rbits[31] && (rbits[30:0] != 31'd0));
        s1_next.prod        = {24'd0, dm} * {8'd0, sig24};
        s1_next.k           = $signed({{3{de[7]}}, de})
                            + ((er != 8'd0) ? ($signed({3'b000, er}) - ftcl_pkg::K_NORM_OFFSET)
                                            : -ftcl_pkg::K_SUB_OFFSET);
        priority if (dm == 8'd0) begin
            s1_next.clamp = ftcl_pkg::CLAMP_LOW;
        end else if (er == 8'hFF) begin
            s1_next.clamp = ftcl_pkg::CLAMP_HIGH;
        end else if (rbits[30:0] == 31'd0) begin
            s1_next.clamp = ftcl_pkg::CLAMP_LOW;
        end else begin
            s1_next.clamp = ftcl_pkg::CLAMP_NONE;
        end
    end

    // Stage 2: leading-one position and result exponent
    always_comb begin
        logic [4:0]         msb;
        logic signed [10:0] ez;
        msb = '0;
        for (int i = 0; i < 32; i++) begin
            if (s1_reg.prod[i]) begin
                msb = 5'(i);
            end
        end
        ez = $signed({6'd0, msb}) + s1_reg.k;
        s2_next.cmd         = s1_reg.cmd;
        s2_next.entry_index = s1_reg.entry_index;
        s2_next.entry_data  = s1_reg.entry_data;
        s2_next.bad         = s1_reg.bad;
        s2_next.prod        = s1_reg.prod;
        s2_next.lzc         = ~msb;
        s2_next.ez          = ez[2:0];
        priority if (s1_reg.clamp != ftcl_pkg::CLAMP_NONE) begin
            s2_next.clamp = s1_reg.clamp;
        end else if (ez < 11'sd0) begin
            s2_next.clamp = ftcl_pkg::CLAMP_LOW;
        end else if (ez > 11'sd7) begin
            s2_next.clamp = ftcl_pkg::CLAMP_HIGH;
        end else begin
            s2_next.clamp = ftcl_pkg::CLAMP_NONE;
        end
    end

    // Stage 3: normalise, round to nearest even, clamp, form index
    always_comb begin
        logic [31:0]                  pn;
        logic                         rnd;
        logic [24:0]                  sum;
        ftcl_pkg::clamp_t             clamp3;
        logic [2:0]                   ez3;
        logic [ftcl_pkg::MANT_W-1:0]  mant3;
        logic [2:0]                   ez_f;
        logic [ftcl_pkg::MANT_W-1:0]  mant_f;
        pn     = s2_reg.prod << s2_reg.lzc;
        rnd    = pn[7] && ((pn[6:0] != 7'd0) || pn[8]);
        sum    = {1'b0, pn[31:8]} + {24'd0, rnd};
        clamp3 = s2_reg.clamp;
        ez3    = s2_reg.ez;
        mant3  = sum[22:0];
        if (s2_reg.clamp == ftcl_pkg::CLAMP_NONE) begin
            if (sum[24]) begin
                mant3 = '0;
                if (s2_reg.ez == 3'd7) begin
                    clamp3 = ftcl_pkg::CLAMP_HIGH;
                end else begin
                    ez3 = s2_reg.ez + 3'd1;
                end
            end else if ((s2_reg.ez == 3'd7) && (sum[23:0] > ftcl_pkg::SIG_HIGH)) begin
                clamp3 = ftcl_pkg::CLAMP_HIGH;
            end
        end
        unique case (clamp3)
            ftcl_pkg::CLAMP_LOW: begin
                ez_f   = 3'd0;
                mant_f = '0;
            end
            ftcl_pkg::CLAMP_HIGH: begin
                ez_f   = 3'd7;
                mant_f = ftcl_pkg::Z_HIGH_MANT;
            end
            default: begin
                ez_f   = ez3;
                mant_f = mant3;
            end
        endcase
        s3_next.cmd         = s2_reg.cmd;
        s3_next.entry_index = s2_reg.entry_index;
        s3_next.entry_data  = s2_reg.entry_data;
        s3_next.bad         = s2_reg.bad;
        s3_next.table_idx   = {ez_f, mant_f[22:19]};
        s3_next.frac        = mant_f[ftcl_pkg::FRAC_W-1:0];
    end

    // Stage 4: table access; writes retire here
    assign ram_wr_en = v3_reg && rdy4 && !s3_reg.cmd;
    assign ram_rd_en = v3_reg && rdy4 && s3_reg.cmd;

    ftcl_ram #(
        .WIDTH(ftcl_pkg::ENTRY_W),
        .DEPTH(ftcl_pkg::TABLE_ENTRIES)
    ) u_table (
        .clk     (aclk),
        .wr_en   (ram_wr_en),
        .wr_addr (s3_reg.entry_index),
        .wr_data (s3_reg.entry_data),
        .rd_en   (ram_rd_en),
        .rd_addr (s3_reg.table_idx),
        .rd_data (ram_rd_data)
    );

    assign s4_next.bad  = s3_reg.bad;
    assign s4_next.frac = s3_reg.frac;

    // Stage 5: (next - current) * fraction
    always_comb begin
        logic signed [8:0] diff;
        diff = $signed({1'b0, ram_rd_data[7:0]}) - $signed({1'b0, ram_rd_data[15:8]});
        s5_next.bad   = s4_reg.bad;
        s5_next.cur   = ram_rd_data[15:8];
        s5_next.iprod = diff * $signed({1'b0, s4_reg.frac});
    end

    // Stage 6: current * 2^19 + product
    always_comb begin
        logic signed [28:0] level_sum;
        level_sum  = $signed({2'b00, s5_reg.cur, 19'd0}) + s5_reg.iprod;
        level_next = s5_reg.bad ? '0 : level_sum[ftcl_pkg::LEVEL_W-1:0];
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            v1_reg       <= 1'b0;
            v2_reg       <= 1'b0;
            v3_reg       <= 1'b0;
            v4_reg       <= 1'b0;
            v5_reg       <= 1'b0;
            m_tvalid_reg <= 1'b0;
        end else begin
            if (rdy1) begin
                v1_reg <= s_tvalid;
            end
            if (rdy2) begin
                v2_reg <= v1_reg;
            end
            if (rdy3) begin
                v3_reg <= v2_reg;
            end
            if (rdy4) begin
                v4_reg <= v3_reg && s3_reg.cmd;
            end
            if (rdy5) begin
                v5_reg <= v4_reg;
            end
            if (rdy6) begin
                m_tvalid_reg <= v5_reg;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (rdy1) begin
            s1_reg <= s1_next;
        end
        if (rdy2) begin
            s2_reg <= s2_next;
        end
        if (rdy3) begin
            s3_reg <= s3_next;
        end
        if (rdy4) begin
            s4_reg <= s4_next;
        end
        if (rdy5) begin
            s5_reg <= s5_next;
        end
        if (rdy6) begin
            level_reg <= level_next;
            bad_reg   <= s5_reg.bad;
        end
    end

    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = {5'd0, level_reg};
    assign m_tuser  = bad_reg;

`ifndef SYNTHESIS
    a_ram_port_excl: assert property (@(posedge aclk) disable iff (!aresetn)
        !(ram_wr_en && ram_rd_en))
        else $error("table write and read in the same cycle");

    a_ram_data_held: assert property (@(posedge aclk) disable iff (!aresetn)
        (v4_reg && !rdy5) |-> !ram_rd_en)
        else $error("table read data overwritten while stage 4 stalled");

    a_bad_level_zero: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_tvalid && m_tuser) |-> (m_tdata == 32'd0))
        else $error("bad depth beat with nonzero level");

    a_level_range: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid |-> (m_tdata <= 32'd133693440))
        else $error("fog level above full scale");
`endif

endmodule
`default_nettype wire
